[src/mffr_pkg.sv]
// Package for the motor feedback frame receiver.
// Holds frame constants, status and kind codes, and the result item type.
// No dependencies.
`default_nettype none

package mffr_pkg;

    localparam int FRAME_BYTES = 10;
    localparam int STORED_BYTES = FRAME_BYTES - 1;
    localparam int IDX_W = $clog2(FRAME_BYTES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_BYTES - 1);

    localparam logic [7:0] CRC_POLY = 8'h8C;
    localparam logic [7:0] CODE_DRIVE = 8'h65;
    localparam logic [7:0] CODE_ODOMETRY = 8'h75;
    localparam logic [7:0] CODE_MODE_76 = 8'h76;
    localparam logic [7:0] CODE_MODE_A1 = 8'hA1;
    localparam logic [7:0] MOTOR_ID_RESET = 8'h01;

    typedef enum logic [1:0] {
        ST_ACCEPTED,
        ST_ID_MISMATCH,
        ST_UNKNOWN_CODE,
        ST_CRC_MISMATCH
    } t_status;

    typedef enum logic [1:0] {
        KIND_DRIVE,
        KIND_ODOMETRY,
        KIND_MODE_76,
        KIND_MODE_A1
    } t_kind;

    typedef struct packed {
        t_status            status;
        t_kind              kind;
        logic signed [15:0] speed;
        logic signed [15:0] current;
        logic [7:0]         temp;
        logic [7:0]         fault;
        logic signed [31:0] mileage;
        logic [15:0]        position;
        logic [7:0]         mode;
    } t_result;

endpackage

`default_nettype wire

[src/mffr_crc8.sv]
// Reflected CRC-8 update of one byte, polynomial 0x8C.
// Depends on mffr_pkg for the polynomial.
`default_nettype none

module mffr_crc8
    import mffr_pkg::*;
(
    input  wire logic [7:0] i_crc,
    input  wire logic [7:0] i_data,
    output logic [7:0]      o_crc
);

    logic [7:0] c;

    always_comb begin
        c = i_crc ^ i_data;
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        o_crc = c;
    end

endmodule

`default_nettype wire

[src/mffr_parser.sv]
// Frame assembly, CRC tracking, frame check and held field value registers.
// Depends on mffr_pkg and mffr_crc8.
`default_nettype none

module mffr_parser
    import mffr_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_advance,
    input  wire logic [7:0] i_byte,
    input  wire logic       i_sof,
    input  wire logic [7:0] i_motor_id,
    output logic            o_emit,
    output t_result         o_result
);

    logic [IDX_W-1:0]   r_byte_index;
    logic [7:0]         r_crc;
    logic [7:0]         r_frame [STORED_BYTES];
    logic signed [15:0] r_speed;
    logic signed [15:0] r_current;
    logic [7:0]         r_temp;
    logic [7:0]         r_fault;
    logic signed [31:0] r_mileage;
    logic [15:0]        r_position;
    logic [7:0]         r_mode;

    logic [IDX_W-1:0]   idx;
    logic [7:0]         crc_base;
    logic [7:0]         n_crc;
    logic               known;
    t_kind              kind;
    t_status            status;
    logic signed [15:0] n_speed;
    logic signed [15:0] n_current;
    logic [7:0]         n_temp;
    logic [7:0]         n_fault;
    logic signed [31:0] n_mileage;
    logic [15:0]        n_position;
    logic [7:0]         n_mode;

    assign idx      = i_sof ? '0 : r_byte_index;
    assign crc_base = i_sof ? 8'h00 : r_crc;
    assign o_emit   = (idx == LAST_IDX);

    mffr_crc8 u_crc (
        .i_crc  (crc_base),
        .i_data (i_byte),
        .o_crc  (n_crc)
    );

    always_comb begin
        known = 1'b1;
        case (r_frame[1])
            CODE_DRIVE:    kind = KIND_DRIVE;
            CODE_ODOMETRY: kind = KIND_ODOMETRY;
            CODE_MODE_76:  kind = KIND_MODE_76;
            CODE_MODE_A1:  kind = KIND_MODE_A1;
            default: begin
                kind  = KIND_DRIVE;
                known = 1'b0;
            end
        endcase

        if (r_frame[0] != i_motor_id) begin
            status = ST_ID_MISMATCH;
        end else if (!known) begin
            status = ST_UNKNOWN_CODE;
        end else if (r_crc != i_byte) begin
            status = ST_CRC_MISMATCH;
        end else begin
            status = ST_ACCEPTED;
        end

        n_speed    = r_speed;
        n_current  = r_current;
        n_temp     = r_temp;
        n_fault    = r_fault;
        n_mileage  = r_mileage;
        n_position = r_position;
        n_mode     = r_mode;
        if (status == ST_ACCEPTED) begin
            case (kind)
                KIND_DRIVE: begin
                    n_speed   = {r_frame[2], r_frame[3]};
                    n_current = {r_frame[4], r_frame[5]};
                    n_temp    = r_frame[7];
                    n_fault   = r_frame[8];
                end
                KIND_ODOMETRY: begin
                    n_mileage  = {r_frame[2], r_frame[3], r_frame[4], r_frame[5]};
                    n_position = {r_frame[6], r_frame[7]};
                end
                default: begin
                    n_mode = r_frame[2];
                end
            endcase
        end

        o_result.status   = status;
        o_result.kind     = kind;
        o_result.speed    = n_speed;
        o_result.current  = n_current;
        o_result.temp     = n_temp;
        o_result.fault    = n_fault;
        o_result.mileage  = n_mileage;
        o_result.position = n_position;
        o_result.mode     = n_mode;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_index <= '0;
            r_crc        <= 8'h00;
            r_speed      <= '0;
            r_current    <= '0;
            r_temp       <= '0;
            r_fault      <= '0;
            r_mileage    <= '0;
            r_position   <= '0;
            r_mode       <= '0;
        end else if (i_advance) begin
            if (o_emit) begin
                r_byte_index <= '0;
                r_crc        <= 8'h00;
                r_speed      <= n_speed;
                r_current    <= n_current;
                r_temp       <= n_temp;
                r_fault      <= n_fault;
                r_mileage    <= n_mileage;
                r_position   <= n_position;
                r_mode       <= n_mode;
            end else begin
                r_byte_index <= idx + 1'b1;
                r_crc        <= n_crc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance && !o_emit) begin
            r_frame[idx] <= i_byte;
        end
    end

endmodule

`default_nettype wire

[src/motor_feedback_frame_receiver_unit.sv]
// Top level of the motor feedback frame receiver: input register, parser, result register.
// Depends on mffr_pkg and mffr_parser.
//
//   channel  | direction | handshake                 | payload
//   ---------+-----------+---------------------------+-------------------------------
//   input    | in        | i_in_valid / o_in_stall   | i_rx_byte, i_start_of_frame
//   result   | out       | o_out_valid / i_out_stall | o_frame_status .. o_motor_mode
//   config   | in        | i_cfg_valid / o_cfg_ready | i_cfg_data (motor id)
//
// One byte is accepted per cycle while o_in_stall is low; the tenth byte passes through the input
// register, and the result register loads when the parser stage advances on it.
// The parser stage waits only when it holds a tenth byte and the result register is full
// and stalled.
// Reset is synchronous and active low; it clears the counters, held values and valids.
// The motor id resets to 1 and configuration writes are always taken.
`default_nettype none

module motor_feedback_frame_receiver_unit
    import mffr_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic [7:0]         i_rx_byte,
    input  wire logic               i_start_of_frame,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic [1:0]              o_frame_status,
    output logic [1:0]              o_frame_kind,
    output logic signed [15:0]      o_speed_tenths_rpm,
    output logic signed [15:0]      o_phase_current,
    output logic [7:0]              o_winding_temp,
    output logic [7:0]              o_fault_flags,
    output logic signed [31:0]      o_mileage_turns,
    output logic [15:0]             o_rotor_position,
    output logic [7:0]              o_motor_mode,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [7:0]         i_cfg_data
);

    logic [7:0] r_motor_id_val;
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_sof;
    logic       r_out_valid;
    t_result    r_out;

    logic       emit;
    t_result    result;
    logic       out_free;
    logic       advance;
    logic       in_ready;

    assign out_free = !r_out_valid || !i_out_stall;
    assign advance  = r_in_valid && (!emit || out_free);
    assign in_ready = !r_in_valid || advance;

    assign o_in_stall  = !in_ready;
    assign o_cfg_ready = 1'b1;

    mffr_parser u_parser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_advance  (advance),
        .i_byte     (r_in_byte),
        .i_sof      (r_in_sof),
        .i_motor_id (r_motor_id_val),
        .o_emit     (emit),
        .o_result   (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_motor_id_val <= MOTOR_ID_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_motor_id_val <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_in_valid) begin
            r_in_byte <= i_rx_byte;
            r_in_sof  <= i_start_of_frame;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && emit) begin
            r_out <= result;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_frame_status     = r_out.status;
    assign o_frame_kind       = r_out.kind;
    assign o_speed_tenths_rpm = r_out.speed;
    assign o_phase_current    = r_out.current;
    assign o_winding_temp     = r_out.temp;
    assign o_fault_flags      = r_out.fault;
    assign o_mileage_turns    = r_out.mileage;
    assign o_rotor_position   = r_out.position;
    assign o_motor_mode       = r_out.mode;

endmodule

`default_nettype wire

[src/mffr_checker.sv]
// Port-level checks for the motor feedback frame receiver, bound to the top level.
// Depends on mffr_pkg and motor_feedback_frame_receiver_unit.
`default_nettype none

module mffr_checker
    import mffr_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        o_in_stall,
    input  wire logic        o_out_valid,
    input  wire logic        i_out_stall,
    input  wire logic [1:0]  o_frame_status,
    input  wire logic [1:0]  o_frame_kind,
    input  wire logic [31:0] o_mileage_turns
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("A stalled result item was dropped.");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_frame_status) && $stable(o_mileage_turns))
        else $error("A stalled result item changed.");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("Result valid is set after reset.");

    a_result_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && !o_in_stall, 2))
        else $error("A result item appeared without an input item two cycles earlier.");

    a_unknown_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_frame_status == ST_UNKNOWN_CODE) |-> o_frame_kind == KIND_DRIVE)
        else $error("An unknown feedback code reported a nonzero kind.");

endmodule

bind motor_feedback_frame_receiver_unit mffr_checker u_mffr_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_stall      (o_in_stall),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_frame_status  (o_frame_status),
    .o_frame_kind    (o_frame_kind),
    .o_mileage_turns (o_mileage_turns)
);

`default_nettype wire

[dv/testbench.sv]
// Self-checking testbench for motor_feedback_frame_receiver_unit: a queue-fed byte driver,
// random result stalls, and an in-line frame predictor compared against every result item.
// Depends on mffr_pkg and the RTL under src.
module testbench;
    import mffr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [7:0]  data;
        logic        sof;
        int unsigned gap;
    } t_rx_item;

    localparam logic [7:0] FEEDBACK_CODES [4] = '{CODE_DRIVE, CODE_ODOMETRY, CODE_MODE_76,
                                                  CODE_MODE_A1};

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic [7:0]         i_rx_byte = 8'h00;
    logic               i_start_of_frame = 1'b0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic [1:0]         o_frame_status;
    logic [1:0]         o_frame_kind;
    logic signed [15:0] o_speed_tenths_rpm;
    logic signed [15:0] o_phase_current;
    logic [7:0]         o_winding_temp;
    logic [7:0]         o_fault_flags;
    logic signed [31:0] o_mileage_turns;
    logic [15:0]        o_rotor_position;
    logic [7:0]         o_motor_mode;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [7:0]         i_cfg_data = 8'h00;

    t_rx_item    pending_rx[$];
    t_rx_item    staged_item;
    logic        staged = 1'b0;
    int unsigned hold_off = 0;
    logic        byte_taken = 1'b0;
    int unsigned stall_left = 0;
    bit          in_gaps_on = 1'b1;
    bit          out_stalls_on = 1'b1;
    int unsigned mismatches = 0;

    t_result     expected_reports[$];
    logic [7:0]  model_motor_id = MOTOR_ID_RESET;
    int          rx_pos = 0;
    logic [7:0]  rx_crc = 8'h00;
    logic [7:0]  rx_buf [STORED_BYTES];
    logic [15:0] hold_speed = '0;
    logic [15:0] hold_current = '0;
    logic [7:0]  hold_temp = '0;
    logic [7:0]  hold_fault = '0;
    logic [31:0] hold_mileage = '0;
    logic [15:0] hold_position = '0;
    logic [7:0]  hold_mode = '0;

    motor_feedback_frame_receiver_unit dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_rx_byte          (i_rx_byte),
        .i_start_of_frame   (i_start_of_frame),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_frame_status     (o_frame_status),
        .o_frame_kind       (o_frame_kind),
        .o_speed_tenths_rpm (o_speed_tenths_rpm),
        .o_phase_current    (o_phase_current),
        .o_winding_temp     (o_winding_temp),
        .o_fault_flags      (o_fault_flags),
        .o_mileage_turns    (o_mileage_turns),
        .o_rotor_position   (o_rotor_position),
        .o_motor_mode       (o_motor_mode),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_data         (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [7:0] crc8_maxim_next(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic void absorb_rx_byte(input logic [7:0] b, input logic sof);
        t_result r;
        t_kind   kd;
        bit      known;
        if (sof) begin
            rx_pos = 0;
            rx_crc = 8'h00;
        end
        if (rx_pos < STORED_BYTES) begin
            rx_buf[rx_pos] = b;
            rx_crc = crc8_maxim_next(rx_crc, b);
            rx_pos++;
        end else begin
            known = 1'b1;
            case (rx_buf[1])
                CODE_DRIVE:    kd = KIND_DRIVE;
                CODE_ODOMETRY: kd = KIND_ODOMETRY;
                CODE_MODE_76:  kd = KIND_MODE_76;
                CODE_MODE_A1:  kd = KIND_MODE_A1;
                default: begin
                    kd = KIND_DRIVE;
                    known = 1'b0;
                end
            endcase
            if (rx_buf[0] != model_motor_id) r.status = ST_ID_MISMATCH;
            else if (!known) r.status = ST_UNKNOWN_CODE;
            else if (rx_crc != b) r.status = ST_CRC_MISMATCH;
            else r.status = ST_ACCEPTED;
            if (r.status == ST_ACCEPTED) begin
                case (kd)
                    KIND_DRIVE: begin
                        hold_speed = {rx_buf[2], rx_buf[3]};
                        hold_current = {rx_buf[4], rx_buf[5]};
                        hold_temp = rx_buf[7];
                        hold_fault = rx_buf[8];
                    end
                    KIND_ODOMETRY: begin
                        hold_mileage = {rx_buf[2], rx_buf[3], rx_buf[4], rx_buf[5]};
                        hold_position = {rx_buf[6], rx_buf[7]};
                    end
                    default: hold_mode = rx_buf[2];
                endcase
            end
            rx_pos = 0;
            rx_crc = 8'h00;
            r.kind = kd;
            r.speed = hold_speed;
            r.current = hold_current;
            r.temp = hold_temp;
            r.fault = hold_fault;
            r.mileage = hold_mileage;
            r.position = hold_position;
            r.mode = hold_mode;
            expected_reports.push_back(r);
        end
    endfunction

    function automatic void compare_field(input string name, input logic [31:0] want,
                                          input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin : result_monitor
        t_result want;
        byte_taken <= i_rst_n && i_in_valid && !o_in_stall;
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            absorb_rx_byte(i_rx_byte, i_start_of_frame);
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_reports.size() == 0) begin
                $error("Result item arrived with no expected result pending.");
                mismatches++;
            end else begin
                want = expected_reports.pop_front();
                compare_field("frame_status", 32'(want.status), 32'(o_frame_status));
                compare_field("frame_kind", 32'(want.kind), 32'(o_frame_kind));
                compare_field("speed_tenths_rpm", 32'(want.speed), 32'(o_speed_tenths_rpm));
                compare_field("phase_current", 32'(want.current), 32'(o_phase_current));
                compare_field("winding_temp", 32'(want.temp), 32'(o_winding_temp));
                compare_field("fault_flags", 32'(want.fault), 32'(o_fault_flags));
                compare_field("mileage_turns", 32'(want.mileage), 32'(o_mileage_turns));
                compare_field("rotor_position", 32'(want.position), 32'(o_rotor_position));
                compare_field("motor_mode", 32'(want.mode), 32'(o_motor_mode));
            end
        end
    end

    always @(negedge i_clk) begin : rx_driver
        logic keep;
        keep = i_in_valid && !byte_taken;
        if (!keep && i_rst_n) begin
            if (!staged && pending_rx.size() > 0) begin
                staged_item = pending_rx.pop_front();
                staged = 1'b1;
                hold_off = staged_item.gap;
            end
            if (staged) begin
                if (hold_off == 0) begin
                    i_rx_byte <= staged_item.data;
                    i_start_of_frame <= staged_item.sof;
                    staged = 1'b0;
                    keep = 1'b1;
                end else begin
                    hold_off--;
                end
            end
        end
        i_in_valid <= keep;
    end

    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 75) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 8);
        return $urandom_range(15, 40);
    endfunction

    always @(negedge i_clk) begin : result_stall_gen
        logic stall_now;
        stall_now = 1'b0;
        if (stall_left > 0) begin
            stall_left--;
            stall_now = 1'b1;
        end else if (out_stalls_on && $urandom_range(0, 99) < 25) begin
            stall_left = idle_len() - 1;
            stall_now = 1'b1;
        end
        i_out_stall <= stall_now;
    end

    function automatic void push_rx(input logic [7:0] b, input logic sof);
        t_rx_item it;
        it.data = b;
        it.sof = sof;
        it.gap = (in_gaps_on && $urandom_range(0, 99) >= 60) ? idle_len() : 0;
        pending_rx.push_back(it);
    endfunction

    function automatic void queue_frame(input logic [7:0] id, input logic [7:0] code,
                                        input logic [55:0] body, input bit crc_good,
                                        input bit with_sof);
        logic [7:0] fb [FRAME_BYTES];
        logic [7:0] crc;
        fb[0] = id;
        fb[1] = code;
        for (int k = 0; k < 7; k++) begin
            fb[k + 2] = body[55 - 8 * k -: 8];
        end
        crc = 8'h00;
        for (int k = 0; k < STORED_BYTES; k++) begin
            crc = crc8_maxim_next(crc, fb[k]);
        end
        fb[LAST_IDX] = crc_good ? crc : crc ^ 8'($urandom_range(1, 255));
        for (int k = 0; k < FRAME_BYTES; k++) begin
            push_rx(fb[k], with_sof && k == 0);
        end
    endfunction

    function automatic logic [55:0] random_body();
        return {$urandom(), 24'($urandom())};
    endfunction

    task automatic wait_until_quiet();
        while (pending_rx.size() != 0 || staged || i_in_valid || expected_reports.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_motor_id(input logic [7:0] id);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= id;
        do @(posedge i_clk); while (!o_cfg_ready);
        model_motor_id = id;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic directed_frames();
        queue_frame(8'h01, CODE_DRIVE, {16'h8000, 16'h7FFF, 8'h5A, 8'hFF, 8'h00}, 1'b1, 1'b1);
        // No start flag here: the counter wrapped after the previous frame.
        queue_frame(8'h01, CODE_ODOMETRY, {32'h8000_0000, 16'hFFFF, 8'h3C}, 1'b1, 1'b0);
        queue_frame(8'h01, CODE_MODE_76, {8'hFF, 48'h0}, 1'b1, 1'b1);
        queue_frame(8'h01, CODE_MODE_A1, {8'h00, 48'hFFFF_FFFF_FFFF}, 1'b1, 1'b1);
        // Wrong id, unknown code and bad checksum together; the id fault must win.
        queue_frame(8'h02, 8'h00, random_body(), 1'b0, 1'b1);
        queue_frame(8'h01, 8'hFF, random_body(), 1'b0, 1'b1);
        queue_frame(8'h01, CODE_ODOMETRY, {32'h7FFF_FFFF, 16'h0000, 8'h00}, 1'b0, 1'b1);
        // A partial frame cut short by a new start flag.
        push_rx(8'h01, 1'b1);
        push_rx(CODE_DRIVE, 1'b0);
        push_rx(8'hAA, 1'b0);
        push_rx(8'h55, 1'b0);
        queue_frame(8'h01, CODE_DRIVE, {16'h7FFF, 16'h8000, 8'h00, 8'h00, 8'hFF}, 1'b1, 1'b1);
        // Nine bytes, then a start flag where the tenth byte would be.
        for (int k = 0; k < STORED_BYTES; k++) begin
            push_rx(8'($urandom()), k == 0);
        end
        queue_frame(8'h01, CODE_MODE_76, {8'h80, 48'h0}, 1'b1, 1'b1);
    endtask

    task automatic random_traffic(input logic [7:0] active_id, input int unsigned n_bytes);
        int unsigned sent;
        int unsigned len;
        logic [7:0]  id;
        logic [7:0]  code;
        sent = 0;
        while (sent < n_bytes) begin
            if ($urandom_range(0, 99) < 88) begin
                id = ($urandom_range(0, 99) < 85) ? active_id : 8'($urandom());
                code = ($urandom_range(0, 9) == 0) ? 8'($urandom())
                                                   : FEEDBACK_CODES[$urandom_range(0, 3)];
                queue_frame(id, code, random_body(), $urandom_range(0, 99) < 85,
                            $urandom_range(0, 99) < 70);
                sent += FRAME_BYTES;
            end else begin
                len = $urandom_range(1, 12);
                for (int k = 0; k < len; k++) begin
                    push_rx(8'($urandom()), $urandom_range(0, 3) == 0);
                end
                sent += len;
            end
        end
    endtask

    initial begin
        logic [7:0] id_plan [5];
        id_plan = '{8'h00, 8'hFF, 8'($urandom()), 8'($urandom()), MOTOR_ID_RESET};
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        directed_frames();
        wait_until_quiet();
        for (int p = 0; p < 5; p++) begin
            write_motor_id(id_plan[p]);
            in_gaps_on = (p != 1);
            out_stalls_on = (p != 2);
            random_traffic(id_plan[p], 96);
            wait_until_quiet();
        end
        if (mismatches == 0) begin
            $display("motor_feedback_frame_receiver_unit regression: pass");
        end else begin
            $display("motor_feedback_frame_receiver_unit regression: fail");
        end
        $finish;
    end

    initial begin
        #3_000_000;
        $display("motor_feedback_frame_receiver_unit regression: fail");
        $finish;
    end
endmodule
